/* sv/modular_exponentiation_defines.svh */
// Assertion macros for the modular exponentiation block.
// Used by sv/modular_exponentiation.sv; needs clk_i and rst_ni in scope.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// concurrent assertion on clk_i, off during reset
`define ME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form: antecedent holds, consequent checked in the same cycle
`define ME_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/modexp_pkg.sv */
// Package for the modular exponentiation block: widths, register map, states.
// No dependencies.
package modexp_pkg;

  localparam int unsigned EXP_WIDTH = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = $clog2(DATA_W);
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned APB_W     = 32;

  localparam logic REG_MODULUS = 1'b0;
  localparam logic OP_POWER    = 1'b0;
  localparam logic OP_INVERSE  = 1'b1;

  localparam logic [DATA_W-1:0] MODULUS_RST = DATA_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RED  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_SQR  = 4'b1000
  } state_e;

endpackage

/* sv/modular_exponentiation.sv */
// Top level: 32-bit modular exponentiation, right-to-left square and multiply.
// Depends on modexp_pkg and modular_exponentiation_defines.svh.
// A zero exponent or a modulus below 2 gives the done strobe straight from idle; otherwise
// the base is reduced, then each exponent bit takes a multiply if set and a square if more bits remain.
// One item at a time: busy until the done strobe; each multiply is a run of shift-add steps, one per data bit.
// Reset: asynchronous active low; goes idle, modulus returns to 2.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               op_i,
  input  logic [modexp_pkg::DATA_W-1:0]      base_i,
  input  logic [63:0]                        exponent_i,
  output logic                               done_o,
  output logic [modexp_pkg::DATA_W-1:0]      power_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [modexp_pkg::ADDR_W-1:0]      paddr,
  input  logic [modexp_pkg::APB_W-1:0]       pwdata,
  output logic [modexp_pkg::APB_W-1:0]       prdata,
  output logic                               pready
);

  localparam int unsigned DW = modexp_pkg::DATA_W;
  localparam int unsigned EW = modexp_pkg::EXP_WIDTH;
  localparam int unsigned CW = modexp_pkg::CNT_W;

  modexp_pkg::state_e state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DW-1:0]      power_q, power_d;
  logic [DW-1:0]      modulus_q;
  logic [EW-1:0]      e_q, e_d;
  logic [DW-1:0]      r_q, r_d;
  logic [DW-1:0]      x_q, x_d;
  logic [DW-1:0]      y_q, y_d;
  logic [DW-1:0]      acc_q, acc_d;
  logic [DW-1:0]      sq_q, sq_d;

  logic [63:0]        e_full;
  logic [EW-1:0]      e_eff;
  logic [EW-1:0]      e_sh;
  logic [DW+1:0]      m_ext;
  logic [DW+1:0]      t1, t2, t3;
  logic [DW-1:0]      r_next;
  logic               last;
  logic               wr_en;

  // APB
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == modexp_pkg::REG_MODULUS);
  assign prdata = (paddr[2] == modexp_pkg::REG_MODULUS) ? modulus_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= modexp_pkg::MODULUS_RST;
    end else if (wr_en) begin
      modulus_q <= pwdata[DW-1:0];
    end
  end

  // effective exponent
  assign e_full = (op_i == modexp_pkg::OP_INVERSE) ?
                  {32'b0, modulus_q - DW'(2)} : exponent_i;
  assign e_eff  = e_full[EW-1:0];
  assign e_sh   = e_q >> 1;

  // shared shift-add modular multiply step: r = (2r + y_msb*x) mod m
  assign m_ext  = {2'b00, modulus_q};
  assign t1     = {1'b0, r_q, 1'b0} + (y_q[DW-1] ? {2'b00, x_q} : '0);
  assign t2     = (t1 >= m_ext) ? t1 - m_ext : t1;
  assign t3     = (t2 >= m_ext) ? t2 - m_ext : t2;
  assign r_next = t3[DW-1:0];
  assign last   = (cnt_q == {CW{1'b1}});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    power_d = power_q;
    e_d     = e_q;
    r_d     = r_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    case (state_q)
      modexp_pkg::ST_IDLE: begin
        if (start_i) begin
          e_d = e_eff;
          if (e_eff == '0) begin
            done_d  = 1'b1;
            power_d = DW'(1);
          end else if (modulus_q < DW'(2)) begin
            done_d  = 1'b1;
            power_d = '0;
          end else begin
            state_d = modexp_pkg::ST_RED;
            x_d     = DW'(1);
            y_d     = base_i;
            r_d     = '0;
            cnt_d   = '0;
          end
        end
      end
      modexp_pkg::ST_RED, modexp_pkg::ST_MUL, modexp_pkg::ST_SQR: begin
        r_d   = r_next;
        y_d   = y_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (last) begin
          r_d   = '0;
          cnt_d = '0;
          if (state_q == modexp_pkg::ST_RED) begin
            sq_d  = r_next;
            acc_d = DW'(1);
            if (e_q[0]) begin
              state_d = modexp_pkg::ST_MUL;
              x_d     = DW'(1);
              y_d     = r_next;
            end else begin
              state_d = modexp_pkg::ST_SQR;
              x_d     = r_next;
              y_d     = r_next;
            end
          end else if (state_q == modexp_pkg::ST_MUL) begin
            acc_d = r_next;
            if (e_sh == '0) begin
              state_d = modexp_pkg::ST_IDLE;
              done_d  = 1'b1;
              power_d = r_next;
            end else begin
              state_d = modexp_pkg::ST_SQR;
              x_d     = sq_q;
              y_d     = sq_q;
            end
          end else begin
            sq_d = r_next;
            e_d  = e_sh;
            if (e_sh[0]) begin
              state_d = modexp_pkg::ST_MUL;
              x_d     = acc_q;
              y_d     = r_next;
            end else begin
              state_d = modexp_pkg::ST_SQR;
              x_d     = r_next;
              y_d     = r_next;
            end
          end
        end
      end
      default: begin
        state_d = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= modexp_pkg::ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    power_q <= power_d;
    e_q     <= e_d;
    r_q     <= r_d;
    x_q     <= x_d;
    y_q     <= y_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
  end

  assign busy_o  = (state_q != modexp_pkg::ST_IDLE);
  assign done_o  = done_q;
  assign power_o = power_q;

  `ME_ASSERT(a_start_resp, start_i && !busy_o |=> busy_o || done_o, "accepted item left no trace")
  `ME_ASSERT_IMP(a_done_idle, done_o, !busy_o, "result strobed while still busy")
  `ME_ASSERT_IMP(a_r_reduced, busy_o, r_q < modulus_q, "partial remainder not reduced")
  `ME_ASSERT_IMP(a_acc_reduced, state_q == modexp_pkg::ST_MUL || state_q == modexp_pkg::ST_SQR,
                 acc_q < modulus_q, "accumulator not reduced")

endmodule
